// ===== src/mlc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared types, codes and helpers for the MOSI line coherence controller.
// ----------------------------------------------------------------------------
package mlc_pkg;

  localparam int unsigned ADDR_BITS      = 32;
  localparam int unsigned MODULE_ID_BITS = 4;
  localparam int unsigned CMD_BITS       = 3;
  localparam int unsigned LS_BITS        = 3;

  typedef logic [ADDR_BITS-1:0]      addr_t;
  typedef logic [MODULE_ID_BITS-1:0] mid_t;
  typedef logic [LS_BITS-1:0]        ls_code_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_STORE = 3'd1,
    CMD_GETS  = 3'd2,
    CMD_GETM  = 3'd3,
    CMD_DATA  = 3'd4
  } cmd_e;

  typedef enum logic [7:0] {
    ST_I  = 8'b0000_0001,
    ST_IM = 8'b0000_0010,
    ST_IS = 8'b0000_0100,
    ST_S  = 8'b0000_1000,
    ST_SM = 8'b0001_0000,
    ST_O  = 8'b0010_0000,
    ST_OM = 8'b0100_0000,
    ST_M  = 8'b1000_0000
  } state_e;

  localparam ls_code_t LS_I  = 3'd0;
  localparam ls_code_t LS_IM = 3'd1;
  localparam ls_code_t LS_IS = 3'd2;
  localparam ls_code_t LS_S  = 3'd3;
  localparam ls_code_t LS_SM = 3'd4;
  localparam ls_code_t LS_O  = 3'd5;
  localparam ls_code_t LS_OM = 3'd6;
  localparam ls_code_t LS_M  = 3'd7;

  typedef struct packed {
    logic   issue_gets;
    logic   issue_getm;
    logic   data_to_processor;
    logic   data_to_bus;
    logic   shared_assert;
    logic   miss_event;
    logic   protocol_error;
    state_e next_state;
  } result_t;

  function automatic ls_code_t state_code(input state_e st);
    ls_code_t code;
    unique case (st)
      ST_I:    code = LS_I;
      ST_IM:   code = LS_IM;
      ST_IS:   code = LS_IS;
      ST_S:    code = LS_S;
      ST_SM:   code = LS_SM;
      ST_O:    code = LS_O;
      ST_OM:   code = LS_OM;
      ST_M:    code = LS_M;
      default: code = LS_I;
    endcase
    return code;
  endfunction

endpackage

// ===== src/mlc_transition.sv =====
// ----------------------------------------------------------------------------
// mlc_transition
// Next-state and action decode for one processor request or snooped message.
// ----------------------------------------------------------------------------
module mlc_transition import mlc_pkg::*; (
  input  logic [CMD_BITS-1:0] command_i,
  input  mid_t                source_module_i,
  input  mid_t                own_module_id_i,
  input  state_e              state_i,
  output result_t             result_o
);

  logic own;

  assign own = (source_module_i == own_module_id_i);

  always_comb begin
    result_o            = '0;
    result_o.next_state = state_i;
    unique case (command_i) inside
      CMD_LOAD, CMD_STORE: begin
        unique case (state_i)
          ST_I: begin
            result_o.miss_event = 1'b1;
            if (command_i == CMD_LOAD) begin
              result_o.issue_gets = 1'b1;
              result_o.next_state = ST_IS;
            end else begin
              result_o.issue_getm = 1'b1;
              result_o.next_state = ST_IM;
            end
          end
          ST_S, ST_O: begin
            if (command_i == CMD_LOAD) begin
              result_o.data_to_processor = 1'b1;
            end else begin
              result_o.issue_getm = 1'b1;
              result_o.miss_event = 1'b1;
              result_o.next_state = (state_i == ST_S) ? ST_SM : ST_OM;
            end
          end
          ST_M: begin
            result_o.data_to_processor = 1'b1;
          end
          default: begin
            result_o.protocol_error = 1'b1;
          end
        endcase
      end
      CMD_GETS: begin
        unique case (state_i)
          ST_S: begin
            result_o.shared_assert = 1'b1;
          end
          ST_O, ST_OM: begin
            result_o.shared_assert = 1'b1;
            result_o.data_to_bus   = 1'b1;
          end
          ST_M: begin
            result_o.shared_assert = 1'b1;
            result_o.data_to_bus   = 1'b1;
            result_o.next_state    = ST_O;
          end
          default: begin
          end
        endcase
      end
      CMD_GETM: begin
        unique case (state_i)
          ST_S: begin
            result_o.next_state = ST_I;
          end
          ST_O, ST_M: begin
            result_o.data_to_bus = 1'b1;
            result_o.next_state  = ST_I;
          end
          ST_SM: begin
            if (!own) begin
              result_o.shared_assert = 1'b1;
              result_o.next_state    = ST_IM;
            end
          end
          ST_OM: begin
            result_o.data_to_bus = 1'b1;
            if (!own) begin
              result_o.next_state = ST_IM;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_DATA: begin
        unique case (state_i)
          ST_IM, ST_SM, ST_OM: begin
            result_o.data_to_processor = 1'b1;
            result_o.next_state        = ST_M;
          end
          ST_IS: begin
            result_o.data_to_processor = 1'b1;
            result_o.next_state        = ST_S;
          end
          default: begin
          end
        endcase
      end
      default: begin
        result_o.protocol_error = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/mosi_line_coherence_fsm.sv =====
// ----------------------------------------------------------------------------
// mosi_line_coherence_fsm
// Snooping-bus MOSI coherence controller for a single cache line.
// ----------------------------------------------------------------------------
// a request is held in the input register, then its result in the result register
// throughput: one transaction per cycle while the result side does not stall, set by the
// state update between the input register and the result register
// reset: line state goes to I, own module id to 0, both stages empty
module mosi_line_coherence_fsm import mlc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  mid_t                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_BITS-1:0] command_i,
  input  addr_t               line_address_i,
  input  mid_t                source_module_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                issue_gets_o,
  output logic                issue_getm_o,
  output logic                data_to_processor_o,
  output logic                data_to_bus_o,
  output mid_t                bus_destination_o,
  output logic                shared_assert_o,
  output logic                miss_event_o,
  output logic                protocol_error_o,
  output addr_t               result_address_o,
  output ls_code_t            line_state_o
);

  logic                in_valid_q, in_valid_d;
  logic [CMD_BITS-1:0] cmd_q;
  addr_t               addr_q;
  mid_t                src_q;
  mid_t                own_id_q;
  state_e              state_q;
  logic                out_valid_q, out_valid_d;
  result_t             res;
  logic                in_accept;
  logic                advance;
  logic                any_move;

  logic     gets_q, getm_q, to_proc_q, to_bus_q, shared_q, miss_q, err_q;
  mid_t     dest_q;
  addr_t    raddr_q;
  ls_code_t ls_q;

  mlc_transition u_transition (
    .command_i       (cmd_q),
    .source_module_i (src_q),
    .own_module_id_i (own_id_q),
    .state_i         (state_q),
    .result_o        (res)
  );

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);
  assign any_move    = res.issue_gets || res.issue_getm || res.data_to_processor
                       || res.data_to_bus;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_I;
      own_id_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= res.next_state;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        own_id_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= command_i;
      addr_q <= line_address_i;
      src_q  <= source_module_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      gets_q    <= res.issue_gets;
      getm_q    <= res.issue_getm;
      to_proc_q <= res.data_to_processor;
      to_bus_q  <= res.data_to_bus;
      shared_q  <= res.shared_assert;
      miss_q    <= res.miss_event;
      err_q     <= res.protocol_error;
      dest_q    <= res.data_to_bus ? src_q : '0;
      raddr_q   <= any_move ? addr_q : '0;
      ls_q      <= state_code(res.next_state);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign issue_gets_o        = gets_q;
  assign issue_getm_o        = getm_q;
  assign data_to_processor_o = to_proc_q;
  assign data_to_bus_o       = to_bus_q;
  assign bus_destination_o   = dest_q;
  assign shared_assert_o     = shared_q;
  assign miss_event_o        = miss_q;
  assign protocol_error_o    = err_q;
  assign result_address_o    = raddr_q;
  assign line_state_o        = ls_q;

endmodule

// ===== src/mlc_checker.sv =====
// ----------------------------------------------------------------------------
// mlc_checker
// Port-level checks for the MOSI line coherence controller.
// ----------------------------------------------------------------------------
module mlc_checker import mlc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input logic     issue_gets_o,
  input logic     issue_getm_o,
  input logic     data_to_processor_o,
  input logic     data_to_bus_o,
  input mid_t     bus_destination_o,
  input logic     shared_assert_o,
  input logic     miss_event_o,
  input logic     protocol_error_o,
  input addr_t    result_address_o,
  input ls_code_t line_state_o
);

  // error transactions carry no action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && protocol_error_o |-> !issue_gets_o && !issue_getm_o
      && !data_to_processor_o && !data_to_bus_o && !shared_assert_o && !miss_event_o)
    else $error("action flagged together with protocol error");

  // destination and address are zero when nothing moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_to_bus_o |-> bus_destination_o == '0)
    else $error("bus destination without bus data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !issue_gets_o && !issue_getm_o && !data_to_processor_o
      && !data_to_bus_o |-> result_address_o == '0)
    else $error("result address without request or data");

  // a GETS is only issued on a load miss into IS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && issue_gets_o |-> miss_event_o && line_state_o == LS_IS)
    else $error("GETS issued without miss into IS");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_state_o)
      && $stable(result_address_o))
    else $error("stalled result changed");

endmodule

bind mosi_line_coherence_fsm mlc_checker u_mlc_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MOSI line coherence controller. A directed table
// walks every stable and transient state, both GETM flavors in SM and OM, and
// the error cases. Random traffic follows under several own-id settings. Each
// accepted request is run through a line-state predictor and every result
// transaction is compared field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
  import mlc_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_RSV5 = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_RSV6 = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_RSV7 = 3'd7;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 130;

  typedef struct packed {
    logic     gets;
    logic     getm;
    logic     to_proc;
    logic     to_bus;
    mid_t     dest;
    logic     shared;
    logic     miss;
    logic     err;
    addr_t    addr;
    ls_code_t st;
  } coh_res_t;

  typedef struct {
    logic [CMD_BITS-1:0] cmd;
    addr_t               addr;
    mid_t                src;
    bit                  typed;
    coh_res_t            want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  mid_t                cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [CMD_BITS-1:0] command_i       = '0;
  addr_t               line_address_i  = '0;
  mid_t                source_module_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic                issue_gets_o;
  logic                issue_getm_o;
  logic                data_to_processor_o;
  logic                data_to_bus_o;
  mid_t                bus_destination_o;
  logic                shared_assert_o;
  logic                miss_event_o;
  logic                protocol_error_o;
  addr_t               result_address_o;
  ls_code_t            line_state_o;

  mosi_line_coherence_fsm uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .line_address_i     (line_address_i),
    .source_module_i    (source_module_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .issue_gets_o       (issue_gets_o),
    .issue_getm_o       (issue_getm_o),
    .data_to_processor_o(data_to_processor_o),
    .data_to_bus_o      (data_to_bus_o),
    .bus_destination_o  (bus_destination_o),
    .shared_assert_o    (shared_assert_o),
    .miss_event_o       (miss_event_o),
    .protocol_error_o   (protocol_error_o),
    .result_address_o   (result_address_o),
    .line_state_o       (line_state_o)
  );

  ls_code_t line_st      = LS_I;
  mid_t     own_id       = '0;
  coh_res_t expected_q[$];
  int       mismatch_cnt = 0;
  bit       req_burst    = 1'b0;
  bit       resp_burst   = 1'b0;
  int       stall_left   = 0;

  // error rows, the first load miss and the first fill carry their result inline, own id is 15 here
  dir_row_t dir_tbl [26] = '{
    '{CMD_LOAD,  32'h0000_0000, 4'h0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0, 32'h0000_0000, LS_IS}},
    '{CMD_LOAD,  32'hFFFF_FFFF, 4'hF, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, LS_IS}},
    '{CMD_STORE, 32'h1234_5678, 4'hA, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, LS_IS}},
    '{CMD_RSV5,  32'hFFFF_FFFF, 4'hF, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, LS_IS}},
    '{CMD_RSV6,  32'h0000_0000, 4'h0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, LS_IS}},
    '{CMD_RSV7,  32'hA5A5_A5A5, 4'h5, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, LS_IS}},
    '{CMD_GETS,  32'h0000_1000, 4'h3, 1'b0, '0},
    '{CMD_GETM,  32'h0000_1000, 4'hF, 1'b0, '0},
    '{CMD_DATA,  32'hFFFF_FFFF, 4'hF, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, LS_S}},
    '{CMD_LOAD,  32'h8000_0000, 4'h0, 1'b0, '0},
    '{CMD_GETS,  32'h8000_0000, 4'h3, 1'b0, '0},
    '{CMD_STORE, 32'h7FFF_FFFF, 4'h0, 1'b0, '0},
    '{CMD_GETM,  32'h7FFF_FFFF, 4'hF, 1'b0, '0},
    '{CMD_GETS,  32'h5555_AAAA, 4'h6, 1'b0, '0},
    '{CMD_GETM,  32'h0000_0000, 4'h2, 1'b0, '0},
    '{CMD_STORE, 32'h0000_0000, 4'h0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, LS_IM}},
    '{CMD_DATA,  32'hDEAD_BEEF, 4'h1, 1'b0, '0},
    '{CMD_STORE, 32'h0F0F_0F0F, 4'h7, 1'b0, '0},
    '{CMD_GETS,  32'hFFFF_FFFF, 4'h0, 1'b0, '0},
    '{CMD_LOAD,  32'hC001_D00D, 4'h8, 1'b0, '0},
    '{CMD_STORE, 32'h0000_0001, 4'h4, 1'b0, '0},
    '{CMD_GETS,  32'h1357_9BDF, 4'h9, 1'b0, '0},
    '{CMD_GETM,  32'h2468_ACE0, 4'hF, 1'b0, '0},
    '{CMD_GETM,  32'h3333_CCCC, 4'h1, 1'b0, '0},
    '{CMD_DATA,  32'hFFFF_0000, 4'hE, 1'b0, '0},
    '{CMD_GETM,  32'h0000_FFFF, 4'h5, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic coh_res_t next_line_action(input logic [CMD_BITS-1:0] cmd,
                                                input addr_t addr, input mid_t src);
    coh_res_t r;
    ls_code_t nx;
    r  = '0;
    nx = line_st;
    case (cmd)
      CMD_LOAD, CMD_STORE: begin
        case (line_st)
          LS_I: begin
            r.miss = 1'b1;
            if (cmd == CMD_LOAD) begin
              r.gets = 1'b1;
              nx     = LS_IS;
            end else begin
              r.getm = 1'b1;
              nx     = LS_IM;
            end
          end
          LS_S, LS_O: begin
            if (cmd == CMD_LOAD) begin
              r.to_proc = 1'b1;
            end else begin
              r.getm = 1'b1;
              r.miss = 1'b1;
              nx     = (line_st == LS_S) ? LS_SM : LS_OM;
            end
          end
          LS_M:    r.to_proc = 1'b1;
          default: r.err = 1'b1;
        endcase
      end
      CMD_GETS: begin
        case (line_st)
          LS_S: r.shared = 1'b1;
          LS_O, LS_OM: begin
            r.shared = 1'b1;
            r.to_bus = 1'b1;
          end
          LS_M: begin
            r.shared = 1'b1;
            r.to_bus = 1'b1;
            nx       = LS_O;
          end
          default: ;
        endcase
      end
      CMD_GETM: begin
        case (line_st)
          LS_S: nx = LS_I;
          LS_O, LS_M: begin
            r.to_bus = 1'b1;
            nx       = LS_I;
          end
          LS_SM: begin
            if (src != own_id) begin
              r.shared = 1'b1;
              nx       = LS_IM;
            end
          end
          LS_OM: begin
            r.to_bus = 1'b1;
            if (src != own_id) nx = LS_IM;
          end
          default: ;
        endcase
      end
      CMD_DATA: begin
        case (line_st)
          LS_IM, LS_SM, LS_OM: begin
            r.to_proc = 1'b1;
            nx        = LS_M;
          end
          LS_IS: begin
            r.to_proc = 1'b1;
            nx        = LS_S;
          end
          default: ;
        endcase
      end
      default: r.err = 1'b1;
    endcase
    if (r.to_bus) r.dest = src;
    if (r.gets || r.getm || r.to_proc || r.to_bus) r.addr = addr;
    line_st = nx;
    r.st    = nx;
    return r;
  endfunction

  function automatic int draw_req_gap();
    if ($urandom_range(0, 19) == 0) req_burst = !req_burst;
    return req_burst ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic send_line_req(input logic [CMD_BITS-1:0] cmd, input addr_t addr,
                               input mid_t src, input bit typed, input coh_res_t want);
    int       gap;
    coh_res_t pred;
    gap = draw_req_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    line_address_i  <= addr;
    source_module_i <= src;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = next_line_action(cmd, addr, src);
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic write_own_id(input mid_t id);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    own_id = id;
  endtask

  task automatic drain_line();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // response side back-pressure
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if ($urandom_range(0, 24) == 0) resp_burst = !resp_burst;
      stall_left = resp_burst ? 0 : $urandom_range(0, 13);
    end else if (stall_left > 0 && out_valid_o) begin
      stall_left--;
    end
    out_ready_i <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    coh_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result transaction, state %0d", $time, line_state_o);
        mismatch_cnt++;
      end else begin
        want = expected_q.pop_front();
        cmp_field("issue_gets", 32'(want.gets), 32'(issue_gets_o));
        cmp_field("issue_getm", 32'(want.getm), 32'(issue_getm_o));
        cmp_field("data_to_processor", 32'(want.to_proc), 32'(data_to_processor_o));
        cmp_field("data_to_bus", 32'(want.to_bus), 32'(data_to_bus_o));
        cmp_field("bus_destination", 32'(want.dest), 32'(bus_destination_o));
        cmp_field("shared_assert", 32'(want.shared), 32'(shared_assert_o));
        cmp_field("miss_event", 32'(want.miss), 32'(miss_event_o));
        cmp_field("protocol_error", 32'(want.err), 32'(protocol_error_o));
        cmp_field("result_address", want.addr, result_address_o);
        cmp_field("line_state", 32'(want.st), 32'(line_state_o));
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [CMD_BITS-1:0] cmd;
    addr_t               addr;
    mid_t                src;
    mid_t                id;
    int                  pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_own_id(4'hF);
    foreach (dir_tbl[i])
      send_line_req(dir_tbl[i].cmd, dir_tbl[i].addr, dir_tbl[i].src,
                    dir_tbl[i].typed, dir_tbl[i].want);
    drain_line();

    for (int p = 0; p < RAND_PHASES; p++) begin
      id = (p == 0) ? 4'h0 : (p == 2) ? 4'hF : mid_t'($urandom_range(0, 15));
      write_own_id(id);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25)      cmd = CMD_LOAD;
        else if (pick < 45) cmd = CMD_STORE;
        else if (pick < 60) cmd = CMD_GETS;
        else if (pick < 75) cmd = CMD_GETM;
        else if (pick < 95) cmd = CMD_DATA;
        else begin
          case ($urandom_range(0, 2))
            0:       cmd = CMD_RSV5;
            1:       cmd = CMD_RSV6;
            default: cmd = CMD_RSV7;
          endcase
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)      addr = '0;
        else if (pick == 1) addr = '1;
        else                addr = $urandom;
        src = ($urandom_range(0, 2) == 0) ? own_id : mid_t'($urandom_range(0, 15));
        send_line_req(cmd, addr, src, 1'b0, '0);
      end
      drain_line();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/mlc_pkg.sv
src/mlc_transition.sv
src/mosi_line_coherence_fsm.sv
src/mlc_checker.sv
verif/tb.sv
